/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros : shared concurrent assertion macros
// Clocked checks with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition in one cycle requires a result in the next.
`define ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (res)) \
        else $error("assertion failed");

`endif

/* hdl/kmd_pkg.sv */
// ---------------------------------------------------------------------------
// kmd_pkg : key matrix debouncer shared types and constants
// Item structs, field widths and default sizes.
// ---------------------------------------------------------------------------
package kmd_pkg;

    localparam int KMD_ROWS       = 8;
    localparam int KMD_COLS       = 8;
    localparam int KMD_COUNT_BITS = 4;

    localparam int ROW_W  = 3;   // row field width
    localparam int COL_W  = 8;   // column field width
    localparam int THR_W  = 4;   // threshold register width

    localparam logic [THR_W-1:0] THR_RESET = 4'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] column_levels;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0] row_number;
        logic [COL_W-1:0] held_keys;
        logic [COL_W-1:0] newly_pressed;
        logic [COL_W-1:0] newly_released;
    } t_out_item;

    typedef struct packed {
        logic [COL_W-1:0] held;
        logic [COL_W-1:0] pressed;
        logic [COL_W-1:0] released;
    } t_row_flags;

endpackage

/* hdl/kmd_row_upd.sv */
// ---------------------------------------------------------------------------
// kmd_row_upd : per-row debounce update
// Applies one row sample to a stored row entry, all columns in parallel.
// Entry layout: {counts, debounced, last_raw}, high to low.
// ---------------------------------------------------------------------------
module kmd_row_upd import kmd_pkg::*; #(
    parameter int NC = KMD_COLS,
    parameter int CB = KMD_COUNT_BITS
) (
    input  logic [NC*(CB+2)-1:0] i_entry,
    input  logic [COL_W-1:0]     i_levels,
    input  logic [THR_W-1:0]     i_thr,
    output logic [NC*(CB+2)-1:0] o_entry,
    output t_row_flags           o_flags
);

    localparam int DEB_LO = NC;
    localparam int CNT_LO = 2 * NC;
    localparam logic [7:0] CMAX = 8'((1 << CB) - 1);

    logic [7:0]    thr8;
    logic [CB-1:0] thr_c;

    assign thr8  = {4'b0000, i_thr};
    assign thr_c = (thr8 > CMAX) ? CMAX[CB-1:0] : thr8[CB-1:0];

    always_comb begin
        logic [CB-1:0] cnt;
        logic          raw;
        logic          last;
        logic          deb_old;
        logic          deb_new;
        o_entry = i_entry;
        o_flags = '0;
        for (int c = 0; c < NC; c++) begin
            raw     = ~i_levels[c];
            last    = i_entry[c];
            deb_old = i_entry[DEB_LO + c];
            cnt     = i_entry[CNT_LO + c*CB +: CB];
            deb_new = deb_old;
            if (raw == last) begin
                if (cnt < thr_c) begin
                    cnt = cnt + 1'b1;
                end
                if (cnt >= thr_c) begin
                    deb_new = raw;
                end
            end else begin
                last = raw;
                cnt  = '0;
            end
            o_entry[c]                  = last;
            o_entry[DEB_LO + c]         = deb_new;
            o_entry[CNT_LO + c*CB +: CB] = cnt;
            o_flags.held[c]     = deb_new;
            o_flags.pressed[c]  = deb_new & ~deb_old;
            o_flags.released[c] = deb_old & ~deb_new;
        end
    end

endmodule

/* hdl/key_matrix_debouncer_top.sv */
// Result path: the accepting edge loads stage 1 and the RAM read; the row update is
//   then registered into the output register when stage 1 advances.
// Throughput: one item per cycle while the output is not stalled; row state lives in a
//   registered-read RAM, and a read of the row written at the same edge is forwarded from the write data.
// Reset (synchronous, active low): threshold returns to 3, all row valid bits
//   clear so every row reads as zero; no clearing sweep, ready right away.
// ---------------------------------------------------------------------------
// key_matrix_debouncer_top : scanned key matrix counter debouncer
// Per-key saturating match counter per row, debounced state and edge flags.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module key_matrix_debouncer_top import kmd_pkg::*; #(
    parameter int ROWS       = KMD_ROWS,
    parameter int COLS       = KMD_COLS,
    parameter int COUNT_BITS = KMD_COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // row sample items
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    // threshold register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [THR_W-1:0] i_cfg_data
);

    // Columns actually tracked: limited by the 8-bit field.
    localparam int NC     = (COLS < COL_W) ? COLS : COL_W;
    localparam int EW     = NC * (COUNT_BITS + 2);
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // ---------------- configuration ----------------
    logic [THR_W-1:0] r_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // ---------------- handshake ----------------
    logic in_acc;
    logic s1_adv;
    logic mem_we;

    logic             r_s1_vld;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_lvl;
    logic             r_s1_inr;
    logic [ROW_AW-1:0] r_s1_addr;

    logic      r_out_vld;
    t_out_item r_out;

    // Stage 1 moves on whenever the output register is empty or draining.
    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign mem_we     = s1_adv && r_s1_inr;

    // ---------------- address decode ----------------
    logic [4:0]        in_row5;
    logic [ROW_AW-1:0] rd_addr;
    logic              in_inr;

    assign in_row5 = {2'b00, i_in_item.row_index};
    assign rd_addr = in_row5[ROW_AW-1:0];
    assign in_inr  = {1'b0, in_row5} < 6'(ROWS);

    // ---------------- row state memory ----------------
    // One entry per row: last raw, debounced and counters packed together.
    logic [EW-1:0] mem [ROWS];
    logic [ROWS-1:0] r_row_vld;     // entry written since reset

    logic [EW-1:0] r_rd_data;
    logic          r_rd_vld;
    logic [EW-1:0] r_fwd_data;
    logic          r_fwd;

    logic [EW-1:0] cur_entry;
    logic [EW-1:0] new_entry;
    t_row_flags    flags;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_s1_addr] <= new_entry;
        end
        if (in_acc && in_inr) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (mem_we) begin
                r_row_vld[r_s1_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_rd_vld <= in_inr && r_row_vld[rd_addr];
                // Same row being written this edge: RAM returns old data.
                r_fwd    <= in_inr && mem_we && (r_s1_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_data <= new_entry;
        end
    end

    always_comb begin
        if (r_fwd) begin
            cur_entry = r_fwd_data;
        end else if (r_rd_vld) begin
            cur_entry = r_rd_data;
        end else begin
            cur_entry = '0;
        end
    end

    kmd_row_upd #(
        .NC (NC),
        .CB (COUNT_BITS)
    ) u_row_upd (
        .i_entry  (cur_entry),
        .i_levels (r_s1_lvl),
        .i_thr    (r_thr),
        .o_entry  (new_entry),
        .o_flags  (flags)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row  <= i_in_item.row_index;
            r_s1_lvl  <= i_in_item.column_levels;
            r_s1_inr  <= in_inr;
            r_s1_addr <= rd_addr;
        end
    end

    // ---------------- output register ----------------
    t_out_item n_out;

    always_comb begin
        n_out            = '0;
        n_out.row_number = r_s1_row;
        if (r_s1_inr) begin
            n_out.held_keys      = flags.held;
            n_out.newly_pressed  = flags.pressed;
            n_out.newly_released = flags.released;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // ---------------- assertions ----------------
    logic out_edge_clash;
    logic out_press_unheld;

    assign out_edge_clash   = |(r_out.newly_pressed & r_out.newly_released);
    assign out_press_unheld = |(r_out.newly_pressed & ~r_out.held_keys);

    `ASSERT_NEXT(a_acc_fills_s1, i_clk, i_rst_n, in_acc, r_s1_vld)
    `ASSERT_CLK(a_stall_needs_s1, i_clk, i_rst_n, !o_in_stall || r_s1_vld)
    `ASSERT_CLK(a_edges_disjoint, i_clk, i_rst_n, !r_out_vld || !out_edge_clash)
    `ASSERT_CLK(a_press_held, i_clk, i_rst_n, !r_out_vld || !out_press_unheld)

endmodule

/* tb/sv/key_matrix_debouncer_top_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_matrix_debouncer_top_test : self-checking bench for the matrix debouncer
// Drives row samples through the stall handshake with random gaps, predicts
// each row report from its own per-key counter model, and checks every
// report field in order. Runs through several threshold settings.
// ---------------------------------------------------------------------------
module key_matrix_debouncer_top_test;
    import kmd_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         in_item = '0;
    logic             o_out_valid;
    logic             out_stall = 1'b0;
    t_out_item        o_out_item;
    logic             cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;

    key_matrix_debouncer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Debounce state mirror: last raw pressed bits, per-key match counts and
    // debounced bits, one entry per row. Threshold tracks the register.
    logic [COL_W-1:0]          raw_seen   [KMD_ROWS];
    logic [KMD_COUNT_BITS-1:0] match_count[KMD_ROWS][KMD_COLS];
    logic [COL_W-1:0]          held_state [KMD_ROWS];
    logic [THR_W-1:0]          threshold_now = THR_RESET;

    t_in_item  row_samples[$];       // items waiting to be sent
    t_out_item expected_reports[$];  // reports owed by the block, oldest first
    int        samples_queued = 0;
    int        errors = 0;

    // Driver and monitor pacing.
    int feed_gap = 0;
    bit feed_burst = 1'b0;
    int drain_stall = 0;
    bit drain_burst = 1'b0;
    t_out_item want;

    // Applies one row sample to the mirror and returns the report it owes.
    // Counts saturate at the threshold; the debounced bit only follows the raw
    // level on a matching sample whose count has reached the threshold. A zero
    // threshold means every matching sample updates the debounced bit.
    function automatic t_out_item debounce_row(t_in_item s);
        t_out_item        r;
        logic [COL_W-1:0] held_prev;
        logic [COL_W-1:0] after;
        logic [COL_W-1:0] closed;
        logic [KMD_COUNT_BITS-1:0] cnt;
        held_prev = held_state[s.row_index];
        after  = held_prev;
        closed = ~s.column_levels;  // active-low columns
        for (int c = 0; c < KMD_COLS; c++) begin
            cnt = match_count[s.row_index][c];
            if (closed[c] == raw_seen[s.row_index][c]) begin
                if (cnt < threshold_now)
                    cnt++;
                if (cnt >= threshold_now)
                    after[c] = closed[c];
            end else begin
                raw_seen[s.row_index][c] = closed[c];
                cnt = '0;
            end
            match_count[s.row_index][c] = cnt;
        end
        held_state[s.row_index] = after;
        r.row_number     = s.row_index;
        r.held_keys      = after;
        r.newly_pressed  = after & ~held_prev;
        r.newly_released = held_prev & ~after;
        return r;
    endfunction

    // Driver: one item in flight on the input side, a random gap after each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (in_valid && !o_in_stall)
                expected_reports.push_back(debounce_row(in_item));
            if (!in_valid || !o_in_stall) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    in_valid <= 1'b0;
                end else if (row_samples.size() > 0) begin
                    in_item  <= row_samples.pop_front();
                    in_valid <= 1'b1;
                    // occasionally flip into or out of a back-to-back stretch
                    if ($urandom_range(0, 31) == 0)
                        feed_burst = !feed_burst;
                    feed_gap = feed_burst ? 0 : $urandom_range(0, 7);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall after each report, checks fields against the
    // oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            drain_stall = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report for row %0d", o_out_item.row_number);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    if (o_out_item.row_number !== want.row_number) begin
                        $error("row_number: expected %0d, actual %0d",
                               want.row_number, o_out_item.row_number);
                        errors++;
                    end
                    if (o_out_item.held_keys !== want.held_keys) begin
                        $error("held_keys: expected %h, actual %h",
                               want.held_keys, o_out_item.held_keys);
                        errors++;
                    end
                    if (o_out_item.newly_pressed !== want.newly_pressed) begin
                        $error("newly_pressed: expected %h, actual %h",
                               want.newly_pressed, o_out_item.newly_pressed);
                        errors++;
                    end
                    if (o_out_item.newly_released !== want.newly_released) begin
                        $error("newly_released: expected %h, actual %h",
                               want.newly_released, o_out_item.newly_released);
                        errors++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    drain_burst = !drain_burst;
                drain_stall = drain_burst ? 0 : $urandom_range(0, 7);
            end
            if (drain_stall > 0) begin
                drain_stall--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic void queue_sample(logic [ROW_W-1:0] row, logic [COL_W-1:0] levels);
        t_in_item s;
        s.row_index     = row;
        s.column_levels = levels;
        row_samples.push_back(s);
        samples_queued++;
    endfunction

    // Threshold write; only called with nothing in flight.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        threshold_now = value;
    endtask

    task automatic wait_drained();
        while (row_samples.size() > 0 || in_valid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // One key press/release episode on a row: some bounce, then a run of the
    // settled level around the threshold length, with other rows mixed in.
    task automatic queue_key_episode(input int thr);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] target;
        int               n;
        row    = ROW_W'($urandom_range(0, KMD_ROWS - 1));
        target = COL_W'($urandom);
        n = $urandom_range(0, 3);
        repeat (n)
            queue_sample(row, target ^ 8'($urandom_range(1, 255)));
        n = thr + $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(0, thr);  // cut short before it settles
        repeat (n) begin
            if ($urandom_range(0, 5) == 0)
                queue_sample(3'($urandom), 8'($urandom));
            queue_sample(row, target);
        end
        // plain noise now and then
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4))
                queue_sample(3'($urandom), 8'($urandom));
    endtask

    int phase_thr[6] = '{0, 15, 1, 8, 2, 5};
    int thr_pick;
    int budget;

    initial begin
        for (int r = 0; r < KMD_ROWS; r++) begin
            raw_seen[r]   = '0;
            held_state[r] = '0;
            for (int c = 0; c < KMD_COLS; c++)
                match_count[r][c] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset threshold of 3.
        repeat (4) queue_sample(3'd0, 8'h00);  // whole row closes
        repeat (4) queue_sample(3'd0, 8'hFF);  // whole row opens
        queue_sample(3'd7, 8'h55);             // bouncing row never settles
        queue_sample(3'd7, 8'hAA);
        queue_sample(3'd7, 8'h55);
        queue_sample(3'd7, 8'hAA);
        repeat (4) queue_sample(3'd7, 8'h0F);
        repeat (4) queue_sample(3'd5, 8'h7E);  // outer columns only
        wait_drained();

        // Random phases across threshold settings, zero and max included.
        foreach (phase_thr[p]) begin
            thr_pick = (p == 4) ? $urandom_range(0, 15) : phase_thr[p];
            write_threshold(THR_W'(thr_pick));
            if (thr_pick == 0) begin
                // zero threshold: the first matching sample already settles
                queue_sample(3'd3, 8'hF0);
                queue_sample(3'd3, 8'hF0);
                queue_sample(3'd3, 8'hFF);
                queue_sample(3'd3, 8'hFF);
            end
            budget = samples_queued + 62;
            while (samples_queued < budget)
                queue_key_episode(thr_pick);
            wait_drained();
        end
        write_threshold(THR_RESET);
        repeat (30) queue_sample(3'($urandom), 8'($urandom));
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d reports never arrived", expected_reports.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* key_matrix_debouncer_top.f */
+incdir+hdl
hdl/kmd_pkg.sv
hdl/kmd_row_upd.sv
hdl/key_matrix_debouncer_top.sv
tb/sv/key_matrix_debouncer_top_test.sv
